// ===== rtl/core/dmpl_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpl_pkg
// shared types and constants of the directory map parse and lookup core
// ----------------------------------------------------------------------------
package dmpl_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned NameW      = 72;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_BYTE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_SHELL_SECTOR = 2'd0,
    CFG_SHELL_SIZE   = 2'd1,
    CFG_MAP_SECTOR   = 2'd2,
    CFG_MAP_SIZE     = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    PH_NAME   = 2'd0,
    PH_SECTOR = 2'd1,
    PH_COUNT  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  localparam logic [7:0]  ChColon   = 8'h3A;
  localparam logic [7:0]  ChSlash   = 8'h2F;
  localparam logic [7:0]  ChClose   = 8'h5D;
  localparam logic [63:0] ShellHead = 64'h6C6568735F737973;
  localparam logic [7:0]  ShellTail = 8'h6C;
  localparam logic [63:0] MapHead   = 64'h000070616D5F7366;
  localparam logic [7:0]  MapTail   = 8'h00;

endpackage

// ===== rtl/core/directory_map_parse_and_lookup_core.sv =====
// ----------------------------------------------------------------------------
// directory_map_parse_and_lookup_core
// parses a name:sector:count directory map and looks names up in it
// ----------------------------------------------------------------------------
// clear, map byte and unused operations take one beat in and present the result
// beat the cycle after acceptance. a lookup of a reserved name, or of any name
// while the table is empty, does the same; any other lookup walks the stored
// table through one synchronous memory port, a read state and a compare state
// per entry, before it presents its result. one item is in flight at a time;
// the result register holds its beat until taken.
// ----------------------------------------------------------------------------
module directory_map_parse_and_lookup_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           operation_i,
  input  logic [7:0]           map_byte_i,
  input  logic [63:0]          name_head_i,
  input  logic [7:0]           name_tail_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [15:0]          sector_o,
  output logic [7:0]           sector_count_o,
  output logic [5:0]           entry_count_o,
  output logic                 parse_done_o,
  output logic                 table_full_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import dmpl_pkg::*;

  // one memory holds name, sector and count of each record
  logic [NameW+23:0] mem_q [TableDepth];
  logic [NameW+23:0] rd_q;
  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;
  logic [NameW+23:0] wr_data;
  logic              rd_en;
  logic [IdxW-1:0]   rd_idx;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  // config registers
  logic [15:0] shell_sec_q, map_sec_q;
  logic [7:0]  shell_size_q, map_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shell_sec_q  <= 16'h0024;
      shell_size_q <= 8'h12;
      map_sec_q    <= 16'h0023;
      map_size_q   <= 8'h01;
    end else if (cfg_valid_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_SHELL_SECTOR: shell_sec_q  <= cfg_data_i;
        CFG_SHELL_SIZE:   shell_size_q <= cfg_data_i[7:0];
        CFG_MAP_SECTOR:   map_sec_q    <= cfg_data_i;
        CFG_MAP_SIZE:     map_size_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // parse state
  phase_e          phase_q, phase_d;
  logic [3:0]      pos_q, pos_d;
  logic [15:0]     acc_q, acc_d;
  logic            ended_q, ended_d;
  logic [NameW-1:0] nbuf_q, nbuf_d;
  logic            first_q, first_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] total_q, total_d;
  logic [15:0]     sec_hold_q, sec_hold_d;

  // control
  state_e          state_q, state_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [63:0]     key_head_q;
  logic [7:0]      key_tail_q;
  logic            found_q, found_d;
  logic [15:0]     osec_q, osec_d;
  logic [7:0]      ocnt_q, ocnt_d;

  logic accept;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT);

  // digit step shared by the number fields
  logic        is_digit;
  logic [15:0] acc_next;
  assign is_digit = (map_byte_i >= 8'h30) && (map_byte_i <= 8'h39);
  assign acc_next = 16'((acc_q << 3) + (acc_q << 1) + {8'h00, map_byte_i - 8'h30});

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    ended_d    = ended_q;
    nbuf_d     = nbuf_q;
    first_d    = first_q;
    ovf_d      = ovf_q;
    total_d    = total_q;
    sec_hold_d = sec_hold_q;
    wr_en      = 1'b0;
    wr_idx     = total_q[IdxW-1:0];
    wr_data    = {nbuf_q, sec_hold_q, acc_q[7:0]};
    if (accept && operation_i == OP_CLEAR) begin
      phase_d = PH_NAME;
      pos_d   = '0;
      acc_d   = '0;
      ended_d = 1'b0;
      nbuf_d  = '0;
      first_d = 1'b1;
      ovf_d   = 1'b0;
      total_d = '0;
    end else if (accept && operation_i == OP_BYTE && phase_q != PH_DONE) begin
      if (first_q) begin
        first_d = 1'b0;
      end else begin
        case (phase_q)
          PH_NAME: begin
            if (map_byte_i == ChColon) begin
              phase_d = PH_SECTOR;
              acc_d   = '0;
              ended_d = 1'b0;
            end else if (pos_q < 4'd9) begin
              nbuf_d[pos_q*8 +: 8] = map_byte_i;
              pos_d = pos_q + 4'd1;
            end
          end
          PH_SECTOR: begin
            if (map_byte_i == ChColon) begin
              sec_hold_d = acc_q;
              phase_d    = PH_COUNT;
              acc_d      = '0;
              ended_d    = 1'b0;
            end else if (map_byte_i == ChClose) begin
              phase_d = PH_DONE;
            end else if (!ended_q && is_digit) begin
              acc_d = acc_next;
            end else begin
              ended_d = 1'b1;
            end
          end
          PH_COUNT: begin
            if (map_byte_i == ChSlash || map_byte_i == ChClose) begin
              // record complete: one write with name, sector and count while the table has room
              if (total_q < CntW'(TableDepth)) begin
                wr_en   = 1'b1;
                total_d = total_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
              if (map_byte_i == ChClose) begin
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_NAME;
                pos_d   = '0;
                acc_d   = '0;
                ended_d = 1'b0;
                nbuf_d  = '0;
              end
            end else if (!ended_q && is_digit) begin
              acc_d = acc_next;
            end else begin
              ended_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // lookup sequencer: issue read in SCAN, compare registered data in CMP
  logic hit;
  assign hit = (rd_q[NameW+23:24] == {key_tail_q, key_head_q});
  assign rd_en  = (state_q == ST_SCAN);
  assign rd_idx = scan_q[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    found_d = found_q;
    osec_d  = osec_q;
    ocnt_d  = ocnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          found_d = 1'b0;
          osec_d  = '0;
          ocnt_d  = '0;
          scan_d  = '0;
          state_d = ST_OUT;
          if (operation_i == OP_LOOKUP) begin
            if (name_head_i == ShellHead && name_tail_i == ShellTail) begin
              found_d = 1'b1;
              osec_d  = shell_sec_q;
              ocnt_d  = shell_size_q;
            end else if (name_head_i == MapHead && name_tail_i == MapTail) begin
              found_d = 1'b1;
              osec_d  = map_sec_q;
              ocnt_d  = map_size_q;
            end else if (total_q != '0) begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        scan_d  = scan_q + 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (hit) begin
          found_d = 1'b1;
          osec_d  = rd_q[23:8];
          ocnt_d  = rd_q[7:0];
        end
        state_d = (scan_q == total_q) ? ST_OUT : ST_SCAN;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
      phase_q <= PH_NAME;
      pos_q   <= '0;
      acc_q   <= '0;
      ended_q <= 1'b0;
      nbuf_q  <= '0;
      first_q <= 1'b1;
      ovf_q   <= 1'b0;
      total_q <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      ended_q <= ended_d;
      nbuf_q  <= nbuf_d;
      first_q <= first_d;
      ovf_q   <= ovf_d;
      total_q <= total_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_hold_q <= sec_hold_d;
    osec_q     <= osec_d;
    ocnt_q     <= ocnt_d;
    if (accept) begin
      key_head_q <= name_head_i;
      key_tail_q <= name_tail_i;
    end
  end

  assign found_o        = found_q;
  assign sector_o       = osec_q;
  assign sector_count_o = ocnt_q;
  assign entry_count_o  = 6'(total_q);
  assign parse_done_o   = (phase_q == PH_DONE);
  assign table_full_o   = ovf_q;

  // checks
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(TableDepth)) else $error("entry total past depth");
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !wr_en) else $error("table write during lookup");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_q < total_q)) else $error("scan past stored entries");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sector_o)))
    else $error("result changed while stalled");

endmodule
